// ===== hw/rtl/lpht_pkg.sv =====
`default_nettype none

package lpht_pkg;

    // table geometry: the home slot is the low byte of the hash
    localparam int SLOTS  = 256;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int KEY_W  = 64;
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_FOC    = 2'd2;
    localparam logic [1:0] FUNC_REMOVE = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NEW  = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] found_value;
        logic [IDX_W-1:0]  slot_index;
        logic [CNT_W-1:0]  entries_in_use;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpht_stream_if.sv =====
`default_nettype none

interface lpht_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lpht_ram.sv =====
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table.sv =====
`default_nettype none

// channel | dir | payload                                          | handshake
// req     | in  | func, key, value                                 | valid/ready
// rsp     | out | status, found_value, slot_index, entries_in_use  | valid/ready
//
// an item probes 1 .. 256 slots: the sequencer accepts it and starts the key read,
// probes the slots in turn through the single key memory read port and
// comparator, then commits and loads the result
// reset clears the occupancy bits and the entry count; no memory clearing pass
// the result sits in an output register; a stalled rsp holds the commit cycle
// and req is ready only while the sequencer is idle

module linear_probe_hash_table #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lpht_stream_if.sink   req,
    lpht_stream_if.source rsp
);
    import lpht_pkg::*;

    // values beyond the port width are cut by the port anyway
    localparam int VW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    // probe outcomes
    localparam logic [1:0] PR_MATCH = 2'd0;
    localparam logic [1:0] PR_FREE  = 2'd1;
    localparam logic [1:0] PR_FULL  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       outcome_reg, outcome_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] steps_reg, steps_next;
    logic [SLOTS-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    // latched request payload
    logic [1:0]       func_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VW-1:0]    value_reg;

    logic             req_fire;
    logic             done_fire;
    logic [IDX_W-1:0] home_idx;
    logic [IDX_W-1:0] key_raddr;
    logic [KEY_W-1:0] key_rdata;
    logic             key_we;
    logic [VW-1:0]    val_rdata;
    logic             val_we;
    logic [VW-1:0]    val_wdata;
    logic             slot_used;

    // hash is the key itself with zero taken as one, modulo the slot count
    assign home_idx  = (req.data.key == '0) ? IDX_W'(1) : req.data.key[IDX_W-1:0];
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign done_fire = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);
    assign slot_used = occ_reg[idx_reg];

    // key read runs one slot ahead while probing so the next slot's key is ready when the probe advances
    assign key_raddr = (state_reg == ST_IDLE) ? home_idx : idx_reg + IDX_W'(1);

    // a newly placed key stores its key; an insert or fresh slot stores a value
    assign key_we = done_fire && (outcome_reg == PR_FREE)
                    && ((func_reg == FUNC_INSERT) || (func_reg == FUNC_FOC));
    assign val_we = done_fire
                    && (((func_reg == FUNC_INSERT) && (outcome_reg != PR_FULL))
                        || ((func_reg == FUNC_FOC) && (outcome_reg == PR_FREE)));
    // a fresh find_or_create slot reads as zero, so it is written as zero
    assign val_wdata = (func_reg == FUNC_INSERT) ? value_reg : '0;

    lpht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (idx_reg),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // value read follows the current slot; valid in the commit state
    lpht_ram #(
        .WIDTH (VW),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (idx_reg),
        .wdata (val_wdata),
        .raddr (idx_reg),
        .rdata (val_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        outcome_next   = outcome_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        occ_next       = occ_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    idx_next   = home_idx;
                    steps_next = '0;
                    state_next = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                // key data for idx_reg is on the read port here
                if (!slot_used)
                begin
                    outcome_next = PR_FREE;
                    state_next   = ST_DONE;
                end
                else if (key_rdata == key_reg)
                begin
                    outcome_next = PR_MATCH;
                    state_next   = ST_DONE;
                end
                else if (steps_reg == IDX_W'(SLOTS - 1))
                begin
                    outcome_next = PR_FULL;
                    state_next   = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    steps_next = steps_reg + IDX_W'(1);
                end
            end

            ST_DONE:
            begin
                if (done_fire)
                begin
                    rsp_data_next.found_value = '0;
                    rsp_data_next.slot_index  = idx_reg;
                    case (func_reg)
                        FUNC_INSERT, FUNC_FOC:
                        begin
                            if (outcome_reg == PR_FULL)
                            begin
                                rsp_data_next.status     = STAT_FULL;
                                rsp_data_next.slot_index = '0;
                            end
                            else if (outcome_reg == PR_FREE)
                            begin
                                rsp_data_next.status = STAT_NEW;
                                occ_next[idx_reg]    = 1'b1;
                                count_next           = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                rsp_data_next.status = STAT_OK;
                                if (func_reg == FUNC_FOC)
                                begin
                                    rsp_data_next.found_value = DATA_W'(val_rdata);
                                end
                            end
                        end
                        FUNC_FIND:
                        begin
                            if (outcome_reg == PR_MATCH)
                            begin
                                rsp_data_next.status      = STAT_OK;
                                rsp_data_next.found_value = DATA_W'(val_rdata);
                            end
                            else
                            begin
                                rsp_data_next.status     = STAT_MISS;
                                rsp_data_next.slot_index = '0;
                            end
                        end
                        default:
                        begin
                            // remove frees the slot only, no tombstone
                            if (outcome_reg == PR_MATCH)
                            begin
                                rsp_data_next.status = STAT_OK;
                                occ_next[idx_reg]    = 1'b0;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                            else
                            begin
                                rsp_data_next.status     = STAT_MISS;
                                rsp_data_next.slot_index = '0;
                            end
                        end
                    endcase
                    rsp_data_next.entries_in_use = count_next;
                    rsp_valid_next               = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            outcome_reg   <= PR_MATCH;
            idx_reg       <= '0;
            steps_reg     <= '0;
            occ_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            outcome_reg   <= outcome_next;
            idx_reg       <= idx_next;
            steps_reg     <= steps_next;
            occ_reg       <= occ_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        if (req_fire)
        begin
            func_reg  <= req.data.func;
            key_reg   <= req.data.key;
            value_reg <= req.data.value[VW-1:0];
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

`default_nettype wire

// ===== verif/linear_probe_hash_table_tb.sv =====
`default_nettype none

module linear_probe_hash_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpht_pkg::*;

    localparam int VALUE_WIDTH = 32;
    localparam logic [DATA_W-1:0] VALUE_MASK = DATA_W'((64'd1 << VALUE_WIDTH) - 64'd1);

    // an item can probe every slot, so allow a full sweep plus slack
    localparam int DRAIN_CYCLES   = 300;
    // quiet cycles tolerated: the long receiver hold-off plus a full-sweep item
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 40;
    localparam int POOL_SIZE      = 16;
    localparam int RANDOM_ITEMS   = 150;

    typedef enum logic [1:0] {PROBE_HIT, PROBE_FREE, PROBE_EXHAUSTED} probe_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // tb-side copies of the channel controls, known from time zero
    logic req_valid = 1'b0;
    req_t req_data  = '0;
    logic rsp_ready = 1'b0;

    lpht_stream_if #(.item_t(req_t)) req_if ();
    lpht_stream_if #(.item_t(rsp_t)) rsp_if ();

    assign req_if.valid = req_valid;
    assign req_if.data  = req_data;
    assign rsp_if.ready = rsp_ready;

    linear_probe_hash_table #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // pending requests and the responses they must produce
    req_t req_backlog[$];
    rsp_t expected_rsp_q[$];

    // shadow copy of the table contents
    logic              mirror_used[SLOTS];
    logic [KEY_W-1:0]  mirror_key[SLOTS];
    logic [DATA_W-1:0] mirror_val[SLOTS];
    int                mirror_count;
    int                peak_count = 0;

    int mismatches   = 0;
    int rsp_seen     = 0;
    int quiet_cycles = 0;
    int ops_sent[4]     = '{default: 0};
    int status_seen[4]  = '{default: 0};

    // sender burst state
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall state
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_pos   = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    rsp_t want;

    // walk the chain from the home slot; key 0 shares its home with key 1
    function automatic probe_e probe_slots(input logic [KEY_W-1:0] k, output int unsigned where);
        int unsigned idx;
        idx = (k == '0) ? 1 : k[IDX_W-1:0];
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!mirror_used[idx])
            begin
                where = idx;
                return PROBE_FREE;
            end
            if (mirror_key[idx] == k)
            begin
                where = idx;
                return PROBE_HIT;
            end
            idx = (idx + 1) % SLOTS;
        end
        where = 0;
        return PROBE_EXHAUSTED;
    endfunction

    // apply one request to the shadow table and return the response it must give
    function automatic rsp_t predict_table_op(input req_t r);
        rsp_t        e;
        probe_e      outcome;
        int unsigned where;
        e = '0;
        outcome = probe_slots(r.key, where);
        case (r.func)
            FUNC_INSERT, FUNC_FOC:
            begin
                if (outcome == PROBE_EXHAUSTED)
                    e.status = STAT_FULL;
                else
                begin
                    if (outcome == PROBE_FREE)
                    begin
                        mirror_used[where] = 1'b1;
                        mirror_key[where]  = r.key;
                        mirror_count++;
                        e.status = STAT_NEW;
                    end
                    else
                        e.status = STAT_OK;
                    // a fresh slot reports its cleared value on find_or_create
                    if (r.func == FUNC_INSERT)
                        mirror_val[where] = r.value & VALUE_MASK;
                    else
                        e.found_value = mirror_val[where];
                    e.slot_index = where[IDX_W-1:0];
                end
            end
            FUNC_FIND:
            begin
                if (outcome == PROBE_HIT)
                begin
                    e.status      = STAT_OK;
                    e.found_value = mirror_val[where];
                    e.slot_index  = where[IDX_W-1:0];
                end
                else
                    e.status = STAT_MISS;
            end
            default:
            begin
                // remove frees the slot only, cutting any chain through it
                if (outcome == PROBE_HIT)
                begin
                    mirror_used[where] = 1'b0;
                    mirror_key[where]  = '0;
                    mirror_val[where]  = '0;
                    if (mirror_count > 0)
                        mirror_count--;
                    e.status     = STAT_OK;
                    e.slot_index = where[IDX_W-1:0];
                end
                else
                    e.status = STAT_MISS;
            end
        endcase
        e.entries_in_use = CNT_W'(mirror_count);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        $display("[%0t] response %0d %s: got 0x%0h, expected 0x%0h",
                 $time, rsp_seen, what, got, exp_val);
    endtask

    task automatic queue_req(input logic [1:0] f, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] v);
        req_t r;
        r.func  = f;
        r.key   = k;
        r.value = v;
        req_backlog.push_back(r);
    endtask

    // random key whose home slot is the given index
    function automatic logic [KEY_W-1:0] key_at(input int unsigned home);
        logic [KEY_W-1:0] k;
        k = {$urandom(), $urandom()};
        k[IDX_W-1:0] = home[IDX_W-1:0];
        return k;
    endfunction

    // values lean on the extremes now and then
    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return $urandom();
    endfunction

    // driver: bursts of items with random gaps, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
            foreach (mirror_used[i])
            begin
                mirror_used[i] = 1'b0;
                mirror_val[i]  = '0;
            end
            mirror_count = 0;
        end
        else
        begin
            if (req_valid && req_if.ready)
            begin
                expected_rsp_q.push_back(predict_table_op(req_data));
                ops_sent[req_data.func]++;
                if (mirror_count > peak_count)
                    peak_count = mirror_count;
            end
            // an offered item stays put until it is taken
            if (!(req_valid && !req_if.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    req_data  <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (!hold_done && rsp_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= stall_pat[pat_pos];
                pat_pos = (pat_pos + 1) % 16;
                if (pat_pos == 0)
                begin
                    // some patterns never stall at all
                    stall_pat = 16'($urandom());
                    stall_pat[0] = 1'b1;
                    if ($urandom_range(0, 2) == 0)
                        stall_pat = 16'hFFFF;
                end
            end
        end
    end

    // monitor: field-by-field check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
                report_mismatch("arrived with nothing expected", 64'(rsp_if.data), '0);
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.data.status != want.status)
                    report_mismatch("status", 64'(rsp_if.data.status), 64'(want.status));
                if (rsp_if.data.found_value != want.found_value)
                    report_mismatch("found_value", 64'(rsp_if.data.found_value),
                                    64'(want.found_value));
                if (rsp_if.data.slot_index != want.slot_index)
                    report_mismatch("slot_index", 64'(rsp_if.data.slot_index),
                                    64'(want.slot_index));
                if (rsp_if.data.entries_in_use != want.entries_in_use)
                    report_mismatch("entries_in_use", 64'(rsp_if.data.entries_in_use),
                                    64'(want.entries_in_use));
            end
            status_seen[rsp_if.data.status]++;
            rsp_seen <= rsp_seen + 1;
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_if.ready) || (rsp_if.valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     quiet_cycles, expected_rsp_q.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [KEY_W-1:0] pool[POOL_SIZE];
        logic [KEY_W-1:0] fill_keys[SLOTS];
        logic [KEY_W-1:0] k;
        int               perm[SLOTS];
        int               j;
        int               tmp;
        int unsigned      pick;

        // directed: empty-table misses, key 0 vs key 1 on one home slot
        queue_req(FUNC_FIND,   64'd5, $urandom());
        queue_req(FUNC_REMOVE, 64'd5, $urandom());
        queue_req(FUNC_FOC,    64'd0, $urandom());
        queue_req(FUNC_INSERT, 64'd1, '1);
        queue_req(FUNC_INSERT, 64'd0, 32'hA5A5_5A5A);
        queue_req(FUNC_FIND,   64'd0, $urandom());
        queue_req(FUNC_FIND,   64'd1, $urandom());
        // top slot, then a collision that wraps to slot 0
        queue_req(FUNC_INSERT, '1, '0);
        queue_req(FUNC_INSERT, 64'h0000_0000_0000_01FF, 32'h8000_0001);
        queue_req(FUNC_FIND,   64'h0000_0000_0000_01FF, $urandom());
        queue_req(FUNC_FOC,    64'h0000_0000_0000_01FF, $urandom());
        // third key on home slot 1 lands behind key 1
        queue_req(FUNC_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0000);
        // removing key 1 cuts the chain: the key behind it can no longer be found
        queue_req(FUNC_REMOVE, 64'd1, $urandom());
        queue_req(FUNC_FIND,   64'h8000_0000_0000_0001, $urandom());
        queue_req(FUNC_FOC,    64'h8000_0000_0000_0001, $urandom());
        queue_req(FUNC_REMOVE, 64'd0, $urandom());
        queue_req(FUNC_REMOVE, 64'd0, $urandom());
        queue_req(FUNC_INSERT, 64'd0, 32'd1);
        queue_req(FUNC_FIND,   '1, $urandom());
        queue_req(FUNC_REMOVE, '1, $urandom());
        queue_req(FUNC_REMOVE, 64'h0000_0000_0000_01FF, $urandom());
        queue_req(FUNC_REMOVE, 64'h8000_0000_0000_0001, $urandom());

        // random traffic on a small pool of keys crowded onto a few home slots
        pool[0] = 64'd0;
        pool[1] = 64'd1;
        pool[2] = '1;
        for (int i = 3; i < POOL_SIZE; i++)
            pool[i] = key_at($urandom_range(0, 1) ? $urandom_range(0, 4)
                                                  : $urandom_range(SLOTS - 2, SLOTS - 1));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            // occasional stray key for misses and scattered entries
            k = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()}
                                            : pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 35)
                queue_req(FUNC_INSERT, k, pick_value());
            else if (pick < 60)
                queue_req(FUNC_FIND, k, $urandom());
            else if (pick < 80)
                queue_req(FUNC_FOC, k, $urandom());
            else
                queue_req(FUNC_REMOVE, k, $urandom());
        end
        foreach (pool[i])
            queue_req(FUNC_REMOVE, pool[i], $urandom());

        // fill every home slot in shuffled order until the table is full
        foreach (perm[i])
            perm[i] = i;
        for (int i = SLOTS - 1; i > 0; i--)
        begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        foreach (fill_keys[i])
        begin
            fill_keys[i] = key_at(perm[i]);
            queue_req(FUNC_INSERT, fill_keys[i], pick_value());
        end

        // full table: new keys are refused, misses sweep every slot
        queue_req(FUNC_INSERT, {$urandom(), $urandom()}, $urandom());
        queue_req(FUNC_FOC,    {$urandom(), $urandom()}, $urandom());
        queue_req(FUNC_FIND,   {$urandom(), $urandom()}, $urandom());
        queue_req(FUNC_REMOVE, {$urandom(), $urandom()}, $urandom());
        queue_req(FUNC_FIND,   fill_keys[0], $urandom());
        queue_req(FUNC_INSERT, fill_keys[0], pick_value());
        queue_req(FUNC_FOC,    fill_keys[1], $urandom());

        // partial drain, then look some of them up again
        for (int i = 0; i < 60; i++)
            queue_req(FUNC_REMOVE, fill_keys[$urandom_range(0, SLOTS - 1)], $urandom());
        for (int i = 0; i < 10; i++)
            queue_req(FUNC_FIND, fill_keys[$urandom_range(0, SLOTS - 1)], $urandom());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the backlog to empty and every response to come back
        while (req_backlog.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ops: %0d insert, %0d find, %0d find_or_create, %0d remove; peak %0d/%0d",
                 ops_sent[FUNC_INSERT], ops_sent[FUNC_FIND], ops_sent[FUNC_FOC],
                 ops_sent[FUNC_REMOVE], peak_count, SLOTS);
        $display("responses: %0d hit, %0d placed, %0d missed, %0d full, %0d mismatches",
                 status_seen[STAT_OK], status_seen[STAT_NEW], status_seen[STAT_MISS],
                 status_seen[STAT_FULL], mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_stream_if.sv
hw/rtl/lpht_ram.sv
hw/rtl/linear_probe_hash_table.sv
verif/linear_probe_hash_table_tb.sv
